[rtl/core/lpg_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lpg_pkg
// Shared types and constants for the LED pattern generator core: register
// map, pattern modes, controller states and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package lpg_pkg;

    localparam int PERIOD_W   = 32;   // period_ms and burst_gap_ms
    localparam int COUNT_W    = 8;    // flash_count
    localparam int DMAX_W     = 8;    // duty_max
    localparam int MODE_W     = 3;    // pattern_mode
    localparam int CFG_IDX_W  = 3;
    localparam int NOW_W      = 32;   // now_ms field
    localparam int DOUT_W     = 8;    // duty_out field
    localparam int TRAIN_W    = PERIOD_W + COUNT_W;
    localparam int BURST_W    = TRAIN_W + 1;
    localparam int ROM_W      = 16;   // Q1.15, 1.0 = 32768
    localparam int ROM_FRAC   = 15;

    // pi in Q30
    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PATTERN_MODE = 3'd0,
        CFG_PERIOD_MS    = 3'd1,
        CFG_FLASH_COUNT  = 3'd2,
        CFG_BURST_GAP_MS = 3'd3,
        CFG_DUTY_MAX     = 3'd4
    } cfg_reg_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_STOP  = 3'd0,
        MODE_SOLID = 3'd1,
        MODE_BLINK = 3'd2,
        MODE_FLASH = 3'd3,
        MODE_PULSE = 3'd4
    } mode_t;

    typedef enum logic {
        OP_TICK   = 1'b0,
        OP_INVERT = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        DIV_FLASH = 2'd0,   // twice the elapsed time
        DIV_MOD   = 2'd1,   // current time
        DIV_IDX   = 2'd2    // scaled remainder
    } div_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_BURST,
        S_EVAL,
        S_FLASH_DIV,
        S_PULSE_MOD,
        S_PULSE_SCALE,
        S_PULSE_IDX,
        S_PULSE_ROM,
        S_PULSE_MUL,
        S_OUT
    } state_t;

    typedef struct packed {
        logic [MODE_W-1:0]   pattern_mode;
        logic [PERIOD_W-1:0] period_ms;
        logic [COUNT_W-1:0]  flash_count;
        logic [PERIOD_W-1:0] burst_gap_ms;
        logic [DMAX_W-1:0]   duty_max;
    } cfg_t;

    typedef struct packed {
        logic     capture;
        logic     burst_load;
        logic     phase_advance;
        logic     phase_restart;
        logic     duty_max_load;
        logic     duty_toggle;
        logic     duty_clear;
        logic     div_start;
        div_sel_t div_sel;
        logic     duty_from_qbit;
        logic     scale_load;
        logic     rom_load;
        logic     prod_load;
        logic     duty_from_prod;
        logic     out_load;
    } dp_cmd_t;

    typedef struct packed {
        op_t               op;
        logic [MODE_W-1:0] mode;
        logic              period_zero;
        logic              blink_due;
        logic              burst_over;
        logic              in_gap;
        logic              div_done;
    } dp_status_t;

endpackage
`default_nettype wire

[rtl/core/lpg_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lpg_div
// Restoring divider, one quotient bit per cycle. Divisor must be nonzero.
// ----------------------------------------------------------------------------
module lpg_div
    import lpg_pkg::*;
#(
    parameter int DIV_W = 40
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [DIV_W-1:0]    dividend,
    input  wire logic [PERIOD_W-1:0] divisor,
    output logic                     done,
    output logic [DIV_W-1:0]         quotient,
    output logic [PERIOD_W-1:0]      remainder
);

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic                busy_reg;
    logic                done_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [DIV_W-1:0]    quot_reg;
    logic [DIV_W-1:0]    quot_next;
    logic [PERIOD_W-1:0] rem_reg;
    logic [PERIOD_W-1:0] rem_next;
    logic [PERIOD_W-1:0] divisor_reg;
    logic [PERIOD_W:0]   shifted;

    always_comb
    begin
        shifted = {rem_reg, quot_reg[DIV_W-1]};
        if (shifted >= {1'b0, divisor_reg})
        begin
            rem_next  = PERIOD_W'(shifted - {1'b0, divisor_reg});
            quot_next = {quot_reg[DIV_W-2:0], 1'b1};
        end
        else
        begin
            rem_next  = shifted[PERIOD_W-1:0];
            quot_next = {quot_reg[DIV_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= CNT_W'(DIV_W);
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg - CNT_W'(1);
                if (count_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quot_reg    <= dividend;
            rem_reg     <= '0;
            divisor_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quot_reg <= quot_next;
            rem_reg  <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg;

endmodule
`default_nettype wire

[rtl/core/lpg_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lpg_datapath
// Timer and duty registers, burst-length arithmetic, sine table and the
// shared divider, driven step by step from the controller.
// ----------------------------------------------------------------------------
module lpg_datapath
    import lpg_pkg::*;
#(
    parameter int DUTY_BITS    = 8,
    parameter int SINE_ENTRIES = 256,
    parameter int TIME_BITS    = 32
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cfg_t              cfg,
    input  wire logic              operation,
    input  wire logic [NOW_W-1:0]  now_ms,
    input  wire dp_cmd_t           cmd,
    output dp_status_t             status,
    output logic [DOUT_W-1:0]      duty_out,
    output logic                   led_lit
);

    localparam int IDX_BITS = $clog2(SINE_ENTRIES);
    localparam int WIDE_T   = (TIME_BITS > PERIOD_W) ? TIME_BITS : PERIOD_W;
    localparam int DIV_W    = WIDE_T + IDX_BITS;
    localparam int CMP_W    = (TIME_BITS > BURST_W) ? TIME_BITS : BURST_W;
    localparam int NOW_X    = (TIME_BITS > NOW_W) ? TIME_BITS : NOW_W;
    localparam int DUTY_X   = (DUTY_BITS > DMAX_W) ? DUTY_BITS : DMAX_W;
    localparam int HALF_X   = WIDE_T + 1;
    localparam int PROD_W   = DUTY_BITS + ROM_W;
    localparam int SCALE_W  = PERIOD_W + IDX_BITS + 1;

    // sin(pi * i / SINE_ENTRIES) in Q1.15, Taylor series to x^11 in Q30
    function automatic logic [ROM_W-1:0] sine_entry(input int unsigned i);
        logic [63:0] fold;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        longint      sum;
        logic [63:0] q;
        fold = (i <= SINE_ENTRIES - i) ? 64'(i) : 64'(SINE_ENTRIES - i);
        x    = (PI_Q30 * fold) / SINE_ENTRIES;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int k = 1; k <= 5; k++)
        begin
            term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
            if ((k % 2) == 1)
                sum = sum - longint'(term);
            else
                sum = sum + longint'(term);
        end
        if (sum < 0)
            sum = 0;
        q = (64'(sum) + 64'd16384) >> 15;
        if (q > 64'd32768)
            q = 64'd32768;
        return q[ROM_W-1:0];
    endfunction

    logic [ROM_W-1:0] rom_tbl [SINE_ENTRIES];

    for (genvar g = 0; g < SINE_ENTRIES; g++)
    begin : g_rom
        localparam logic [ROM_W-1:0] ENTRY = sine_entry(g);
        assign rom_tbl[g] = ENTRY;
    end

    logic [NOW_X-1:0]        now_wide;
    logic [TIME_BITS-1:0]    now_in;
    logic [DUTY_X-1:0]       dmax_wide;
    logic [DUTY_BITS-1:0]    dmax;
    logic [DUTY_X-1:0]       duty_wide;

    op_t                     op_reg;
    logic [TIME_BITS-1:0]    now_reg;
    logic [TIME_BITS-1:0]    elapsed_reg;
    logic [TRAIN_W-1:0]      train_reg;
    logic [BURST_W-1:0]      burst_reg;
    logic [TIME_BITS-1:0]    phase_start_reg;
    logic [TIME_BITS-1:0]    phase_start_next;
    logic [DUTY_BITS-1:0]    duty_level_reg;
    logic [DUTY_BITS-1:0]    duty_level_next;
    logic [DIV_W-1:0]        scaled_reg;
    logic [ROM_W-1:0]        rom_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic [DOUT_W-1:0]       duty_out_reg;
    logic                    led_lit_reg;

    logic [HALF_X-1:0]           adv_sum;
    logic [CMP_W-1:0]            elapsed_c;
    logic [SCALE_W-1:0]          scaled_full;
    logic [DIV_W-1:0]            div_dividend;
    logic                        div_done;
    logic [DIV_W-1:0]            div_quot;
    logic [PERIOD_W-1:0]         div_rem;

    assign now_wide  = NOW_X'(now_ms);
    assign now_in    = now_wide[TIME_BITS-1:0];
    assign dmax_wide = DUTY_X'(cfg.duty_max);
    assign dmax      = dmax_wide[DUTY_BITS-1:0];
    assign duty_wide = DUTY_X'(duty_level_reg);

    assign adv_sum     = HALF_X'(phase_start_reg) + HALF_X'(cfg.period_ms >> 1);
    assign elapsed_c   = CMP_W'(elapsed_reg);
    assign scaled_full = SCALE_W'(div_rem) * SCALE_W'(SINE_ENTRIES);

    always_comb
    begin
        case (cmd.div_sel)
            DIV_FLASH: div_dividend = DIV_W'({elapsed_reg, 1'b0});
            DIV_MOD:   div_dividend = DIV_W'(now_reg);
            default:   div_dividend = scaled_reg;
        endcase
    end

    lpg_div #(
        .DIV_W (DIV_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (cfg.period_ms),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    always_comb
    begin
        phase_start_next = phase_start_reg;
        if (cmd.phase_advance)
            phase_start_next = adv_sum[TIME_BITS-1:0];
        else if (cmd.phase_restart)
            phase_start_next = now_reg;

        duty_level_next = duty_level_reg;
        if (cmd.duty_max_load)
            duty_level_next = dmax;
        else if (cmd.duty_toggle)
            duty_level_next = (duty_level_reg == '0) ? dmax : '0;
        else if (cmd.duty_clear)
            duty_level_next = '0;
        else if (cmd.duty_from_qbit)
            duty_level_next = div_quot[0] ? dmax : '0;
        else if (cmd.duty_from_prod)
            duty_level_next = prod_reg[ROM_FRAC +: DUTY_BITS];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg          <= OP_TICK;
            phase_start_reg <= '0;
            duty_level_reg  <= '0;
        end
        else
        begin
            if (cmd.capture)
                op_reg <= op_t'(operation);
            phase_start_reg <= phase_start_next;
            duty_level_reg  <= duty_level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            now_reg     <= now_in;
            elapsed_reg <= now_in - phase_start_reg;
            train_reg   <= TRAIN_W'(cfg.period_ms) * TRAIN_W'(cfg.flash_count);
        end
        if (cmd.burst_load)
            burst_reg <= BURST_W'(train_reg) + BURST_W'(cfg.burst_gap_ms);
        if (cmd.scale_load)
            scaled_reg <= DIV_W'(scaled_full);
        if (cmd.rom_load)
            rom_reg <= rom_tbl[div_quot[IDX_BITS-1:0]];
        if (cmd.prod_load)
            prod_reg <= PROD_W'(dmax) * PROD_W'(rom_reg);
        if (cmd.out_load)
        begin
            duty_out_reg <= duty_wide[DOUT_W-1:0];
            led_lit_reg  <= |duty_level_reg;
        end
    end

    always_comb
    begin
        status.op          = op_reg;
        status.mode        = cfg.pattern_mode;
        status.period_zero = (cfg.period_ms == '0);
        status.blink_due   = elapsed_c >= CMP_W'(cfg.period_ms >> 1);
        status.burst_over  = elapsed_c >= CMP_W'(burst_reg);
        status.in_gap      = elapsed_c >= CMP_W'(train_reg);
        status.div_done    = div_done;
    end

    assign duty_out = duty_out_reg;
    assign led_lit  = led_lit_reg;

endmodule
`default_nettype wire

[rtl/core/lpg_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// lpg_ctrl
// Sequencer for one item at a time: decode the mode, run the divider where
// needed, then hand the word to the output register.
// ----------------------------------------------------------------------------
module lpg_ctrl
    import lpg_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  wire logic       out_stall,
    input  wire dp_status_t status,
    output dp_cmd_t         cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.div_sel = DIV_FLASH;
        in_stall   = (state_reg != S_IDLE);

        out_valid_next = out_valid_reg;
        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_BURST;
                end
            end
            S_BURST:
            begin
                cmd.burst_load = 1'b1;
                state_next     = S_EVAL;
            end
            S_EVAL:
            begin
                state_next = S_OUT;
                if (status.op == OP_INVERT)
                    cmd.phase_advance = 1'b1;
                else
                begin
                    unique case (status.mode)
                        MODE_SOLID:
                            cmd.duty_max_load = 1'b1;
                        MODE_BLINK:
                        begin
                            if (status.blink_due)
                            begin
                                cmd.phase_restart = 1'b1;
                                cmd.duty_toggle   = 1'b1;
                            end
                        end
                        MODE_FLASH:
                        begin
                            if (status.burst_over)
                                cmd.phase_restart = 1'b1;
                            else if (status.in_gap || status.period_zero)
                                cmd.duty_clear = 1'b1;
                            else
                            begin
                                cmd.div_start = 1'b1;
                                cmd.div_sel   = DIV_FLASH;
                                state_next    = S_FLASH_DIV;
                            end
                        end
                        MODE_PULSE:
                        begin
                            if (status.period_zero)
                                cmd.duty_clear = 1'b1;
                            else
                            begin
                                cmd.div_start = 1'b1;
                                cmd.div_sel   = DIV_MOD;
                                state_next    = S_PULSE_MOD;
                            end
                        end
                        // stop and the unused codes
                        default:
                            cmd.duty_clear = 1'b1;
                    endcase
                end
            end
            S_FLASH_DIV:
            begin
                cmd.div_sel = DIV_FLASH;
                if (status.div_done)
                begin
                    cmd.duty_from_qbit = 1'b1;
                    state_next         = S_OUT;
                end
            end
            S_PULSE_MOD:
            begin
                cmd.div_sel = DIV_MOD;
                if (status.div_done)
                begin
                    cmd.scale_load = 1'b1;
                    state_next     = S_PULSE_SCALE;
                end
            end
            S_PULSE_SCALE:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_IDX;
                state_next    = S_PULSE_IDX;
            end
            S_PULSE_IDX:
            begin
                cmd.div_sel = DIV_IDX;
                if (status.div_done)
                begin
                    cmd.rom_load = 1'b1;
                    state_next   = S_PULSE_ROM;
                end
            end
            S_PULSE_ROM:
            begin
                cmd.prod_load = 1'b1;
                state_next    = S_PULSE_MUL;
            end
            S_PULSE_MUL:
            begin
                cmd.duty_from_prod = 1'b1;
                state_next         = S_OUT;
            end
            S_OUT:
            begin
                // hold while the previous word is still waiting downstream
                if (!(out_valid_reg && out_stall))
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    assign out_valid = out_valid_reg;

endmodule
`default_nettype wire

[rtl/core/led_pattern_generator_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// led_pattern_generator_core
// LED duty pattern generator: stop, solid, blink, flash bursts and a
// half-sine breathe curve, stepped by millisecond ticks.
// ----------------------------------------------------------------------------
// Each word in gives exactly one word out. Items are handled one at a time:
// a phase-invert event or a tick that needs no division passes through the
// capture, burst, evaluate and output steps to the result register; a flash
// tick inside the pulse train also runs the shared divider once and a pulse
// tick runs it twice, with divider width DIV_W = max(TIME_BITS, 32) +
// log2(SINE_ENTRIES) (40 at the defaults). The shared restoring divider
// yields one quotient bit per cycle. A finished word waits in the output
// register while the next item is taken. Configuration writes are always
// ready and must only be made while the block is idle.
module led_pattern_generator_core
    import lpg_pkg::*;
#(
    parameter int DUTY_BITS    = 8,
    parameter int SINE_ENTRIES = 256,
    parameter int TIME_BITS    = 32
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic                 operation,
    input  wire logic [NOW_W-1:0]     now_ms,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [DOUT_W-1:0]         duty_out,
    output logic                      led_lit,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [PERIOD_W-1:0]  cfg_data
);

    logic [MODE_W-1:0]   pattern_mode_reg;
    logic [PERIOD_W-1:0] period_ms_reg;
    logic [COUNT_W-1:0]  flash_count_reg;
    logic [PERIOD_W-1:0] burst_gap_ms_reg;
    logic [DMAX_W-1:0]   duty_max_reg;

    cfg_t       cfg;
    dp_cmd_t    dp_cmd;
    dp_status_t dp_status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_mode_reg <= MODE_STOP;
            period_ms_reg    <= PERIOD_W'(1000);
            flash_count_reg  <= COUNT_W'(1);
            burst_gap_ms_reg <= '0;
            duty_max_reg     <= DMAX_W'(255);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_PATTERN_MODE: pattern_mode_reg <= cfg_data[MODE_W-1:0];
                CFG_PERIOD_MS:    period_ms_reg    <= cfg_data;
                CFG_FLASH_COUNT:  flash_count_reg  <= cfg_data[COUNT_W-1:0];
                CFG_BURST_GAP_MS: burst_gap_ms_reg <= cfg_data;
                CFG_DUTY_MAX:     duty_max_reg     <= cfg_data[DMAX_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        cfg.pattern_mode = pattern_mode_reg;
        cfg.period_ms    = period_ms_reg;
        cfg.flash_count  = flash_count_reg;
        cfg.burst_gap_ms = burst_gap_ms_reg;
        cfg.duty_max     = duty_max_reg;
    end

    lpg_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (dp_status),
        .cmd       (dp_cmd)
    );

    lpg_datapath #(
        .DUTY_BITS    (DUTY_BITS),
        .SINE_ENTRIES (SINE_ENTRIES),
        .TIME_BITS    (TIME_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .operation (operation),
        .now_ms    (now_ms),
        .cmd       (dp_cmd),
        .status    (dp_status),
        .duty_out  (duty_out),
        .led_lit   (led_lit)
    );

`ifndef SYNTH
    // one item in flight: an accepted word closes the input until its result
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted twice in a row");

    // never overwrite a result that is still waiting downstream
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.out_load |-> !(out_valid && out_stall))
        else $error("output register overwritten while stalled");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.out_load |=> out_valid)
        else $error("loaded result not presented");

    // the divider is only started from the controller's decode steps
    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        dp_status.div_done |-> in_stall)
        else $error("divider finished while idle");
`endif

endmodule
`default_nettype wire

[tb/sv/led_duty_check.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// led_duty_check
// Watches the item, result and register channels of the LED pattern
// generator, keeps its own copy of the pattern state and register values,
// predicts the duty word for every accepted item and compares it with the
// result words in order.
// ----------------------------------------------------------------------------
module led_duty_check
    import lpg_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic                 in_stall,
    input  wire logic                 operation,
    input  wire logic [NOW_W-1:0]     now_ms,
    input  wire logic                 out_valid,
    input  wire logic                 out_stall,
    input  wire logic [DOUT_W-1:0]    duty_out,
    input  wire logic                 led_lit,
    input  wire logic                 cfg_valid,
    input  wire logic                 cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [PERIOD_W-1:0]  cfg_data,
    output int                        mismatches,
    output int                        pending,
    output int                        checked
);

    localparam int SINE_N = 256;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [DOUT_W-1:0] duty;
        logic              lit;
    } led_word_t;

    led_word_t         expected_words[$];
    led_word_t         want;
    logic [ROM_W-1:0]  sine_q15 [0:SINE_N-1];

    // register copy
    logic [MODE_W-1:0]   cur_mode;
    logic [PERIOD_W-1:0] period;
    logic [COUNT_W-1:0]  flash_cnt;
    logic [PERIOD_W-1:0] gap;
    logic [DMAX_W-1:0]   dmax;

    // pattern state
    logic [NOW_W-1:0]    phase_start;
    logic [DOUT_W-1:0]   duty_level;

    // sin(pi * i / SINE_N) in Q1.15, Taylor series to x^11 on the folded angle
    function automatic logic [ROM_W-1:0] sine_q15_entry(int unsigned i);
        longint unsigned fold;
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint unsigned q;
        longint          sum;
        fold = (i <= SINE_N - i) ? 64'(i) : 64'(SINE_N - i);
        x    = (PI_Q30 * fold) / 64'(SINE_N);
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        for (int k = 1; k <= 5; k++)
        begin
            term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
            if (k % 2 == 1)
                sum = sum - $signed(term);
            else
                sum = sum + $signed(term);
        end
        if (sum < 0)
            sum = 0;
        q = ($unsigned(sum) + (64'd1 << 14)) >> 15;
        if (q > 64'd32768)
            q = 64'd32768;
        return q[ROM_W-1:0];
    endfunction

    initial
    begin
        for (int i = 0; i < SINE_N; i++)
            sine_q15[i] = sine_q15_entry(i);
    end

    // apply one item to the pattern state and return the duty word it leaves
    function automatic led_word_t step_pattern(logic op, logic [NOW_W-1:0] now);
        logic [NOW_W-1:0] elapsed;
        logic [63:0]      train;
        logic [63:0]      rem;
        logic [63:0]      idx;
        logic [63:0]      wide;
        led_word_t        res;
        elapsed = now - phase_start;
        if (op_t'(op) == OP_INVERT)
            phase_start = phase_start + (period >> 1);
        else
        begin
            case (cur_mode)
                MODE_SOLID:
                    duty_level = dmax;
                MODE_BLINK:
                begin
                    if (elapsed >= (period >> 1))
                    begin
                        phase_start = now;
                        duty_level  = (duty_level == '0) ? dmax : '0;
                    end
                end
                MODE_FLASH:
                begin
                    train = 64'(period) * 64'(flash_cnt);
                    if (64'(elapsed) >= train + 64'(gap))
                        phase_start = now;   // burst over: restart, keep level
                    else if (64'(elapsed) >= train || period == '0)
                        duty_level = '0;
                    else if ((((64'(elapsed) << 1) / 64'(period)) & 64'd1) != 64'd0)
                        duty_level = dmax;
                    else
                        duty_level = '0;
                end
                MODE_PULSE:
                begin
                    if (period == '0)
                        duty_level = '0;
                    else
                    begin
                        rem = 64'(now % period);
                        idx = (rem * 64'(SINE_N)) / 64'(period);
                        if (idx >= 64'(SINE_N))
                            idx = 64'(SINE_N - 1);
                        wide       = 64'(dmax) * 64'(sine_q15[idx[7:0]]);
                        duty_level = DOUT_W'(wide >> ROM_FRAC);
                    end
                end
                default:
                    duty_level = '0;
            endcase
        end
        res.duty = duty_level;
        res.lit  = (duty_level != '0);
        return res;
    endfunction

    initial
    begin
        mismatches = 0;
        pending    = 0;
        checked    = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_mode    = MODE_STOP;
            period      = 32'd1000;
            flash_cnt   = 8'd1;
            gap         = '0;
            dmax        = 8'd255;
            phase_start = '0;
            duty_level  = '0;
            expected_words.delete();
            pending     = 0;
        end
        else
        begin
            // retire the oldest expectation before taking a new word in
            if (out_valid && !out_stall)
            begin
                checked++;
                if (expected_words.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("Unexpected result word: duty_out %0d led_lit %0d",
                                 duty_out, led_lit);
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (want.duty !== duty_out || want.lit !== led_lit)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display({"Mismatch on result %0d: duty_out expected %0d got %0d,",
                                      " led_lit expected %0d got %0d"},
                                     checked, want.duty, duty_out, want.lit, led_lit);
                    end
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                case (cfg_reg_t'(cfg_index))
                    CFG_PATTERN_MODE: cur_mode  = cfg_data[MODE_W-1:0];
                    CFG_PERIOD_MS:    period    = cfg_data;
                    CFG_FLASH_COUNT:  flash_cnt = cfg_data[COUNT_W-1:0];
                    CFG_BURST_GAP_MS: gap       = cfg_data;
                    CFG_DUTY_MAX:     dmax      = cfg_data[DMAX_W-1:0];
                    default:          ;
                endcase
            end

            if (in_valid && !in_stall)
                expected_words.push_back(step_pattern(operation, now_ms));

            pending = expected_words.size();
        end
    end

endmodule

[tb/sv/tb_led_pattern_generator_core.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_led_pattern_generator_core
// Drives ticks and phase-invert events into the LED pattern generator over a
// series of register settings (every mode, undefined modes, zero and full
// periods, extreme counts, gaps and duty limits), with random idling on both
// sides, a long receiver hold-off and a drain pause. Checking is done by
// led_duty_check beside the block.
// ----------------------------------------------------------------------------
module tb_led_pattern_generator_core;
    import lpg_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 300;
    localparam int TAIL_CYCLES    = 100;
    localparam int RANDOM_PHASES  = 16;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic                 operation;
    logic [NOW_W-1:0]     now_ms;
    logic                 out_valid;
    logic                 out_stall;
    logic [DOUT_W-1:0]    duty_out;
    logic                 led_lit;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [PERIOD_W-1:0]  cfg_data;

    int mismatches;
    int pending;
    int checked;
    int words_sent;
    int settings;
    int quiet_cycles;
    bit calm;
    bit hold_req;

    logic [NOW_W-1:0] now_cursor;

    led_pattern_generator_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .operation (operation),
        .now_ms    (now_ms),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .duty_out  (duty_out),
        .led_lit   (led_lit),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    led_duty_check duty_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .operation  (operation),
        .now_ms     (now_ms),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .duty_out   (duty_out),
        .led_lit    (led_lit),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .mismatches (mismatches),
        .pending    (pending),
        .checked    (checked)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // receiver: random stalls, or one long hold-off on request
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else
                out_stall <= !calm && ($urandom_range(99) < 7);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog: no handshake for %0d cycles, %0d words still due",
                     WATCHDOG_LIMIT, pending);
            $display("tb_led_pattern_generator_core failed");
            $finish;
        end
    end

    // offer one word and hold it until taken; sometimes idle afterwards
    task automatic put_word(op_t op, logic [NOW_W-1:0] t);
        in_valid  <= 1'b1;
        operation <= op;
        now_ms    <= t;
        do @(posedge clk); while (in_stall);
        words_sent++;
        if (!calm && $urandom_range(99) < 7)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [PERIOD_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
    endtask

    // block must be idle: drain first, then write all five registers
    task automatic set_cfg(logic [MODE_W-1:0] mode, logic [PERIOD_W-1:0] per,
                           logic [COUNT_W-1:0] cnt, logic [PERIOD_W-1:0] gap_ms,
                           logic [DMAX_W-1:0] top);
        drain();
        write_reg(CFG_PATTERN_MODE, PERIOD_W'(mode));
        write_reg(CFG_PERIOD_MS, per);
        write_reg(CFG_FLASH_COUNT, PERIOD_W'(cnt));
        write_reg(CFG_BURST_GAP_MS, gap_ms);
        write_reg(CFG_DUTY_MAX, PERIOD_W'(top));
        cfg_valid <= 1'b0;
        settings++;
    endtask

    task automatic run_phase(int n_items, bit do_hold, bit do_pause);
        logic [MODE_W-1:0]   mode;
        logic [PERIOD_W-1:0] per;
        logic [COUNT_W-1:0]  cnt;
        logic [PERIOD_W-1:0] gap_ms;
        logic [DMAX_W-1:0]   top;
        int                  r;
        int unsigned         step_max;
        r = $urandom_range(99);
        if (r < 8)
            mode = MODE_STOP;
        else if (r < 16)
            mode = MODE_SOLID;
        else if (r < 40)
            mode = MODE_BLINK;
        else if (r < 70)
            mode = MODE_FLASH;
        else if (r < 94)
            mode = MODE_PULSE;
        else
            mode = MODE_W'($urandom_range(int'(MODE_PULSE) + 1, (1 << MODE_W) - 1));
        r = $urandom_range(99);
        if (r < 5)
            per = '0;
        else if (r < 10)
            per = '1;
        else if (r < 20)
            per = $urandom();
        else if (r < 50)
            per = $urandom_range(1, 16);
        else
            per = $urandom_range(1, 400);
        r = $urandom_range(99);
        if (r < 6)
            cnt = '0;
        else if (r < 12)
            cnt = '1;
        else if (r < 20)
            cnt = COUNT_W'($urandom_range(0, 255));
        else
            cnt = COUNT_W'($urandom_range(1, 6));
        r = $urandom_range(99);
        if (r < 10)
            gap_ms = '0;
        else if (r < 15)
            gap_ms = '1;
        else if (r < 25)
            gap_ms = $urandom();
        else
            gap_ms = $urandom_range(1, 500);
        r = $urandom_range(99);
        if (r < 10)
            top = '0;
        else if (r < 20)
            top = '1;
        else
            top = DMAX_W'($urandom());
        set_cfg(mode, per, cnt, gap_ms, top);

        // step time in proportion to the period so bursts and curves wrap round
        step_max = (per != '0 && per <= 400) ? per / 3 + 1 : 1000;
        if ($urandom_range(99) < 20)
            now_cursor = '1 - $urandom_range(0, 200);   // cross the time wrap
        else
            now_cursor = $urandom();

        for (int i = 0; i < n_items; i++)
        begin
            if (do_hold && i == 20)
                hold_req = 1'b1;
            if (do_pause && i == n_items / 2)
                drain();
            r = $urandom_range(99);
            if (r < 10)
                put_word(OP_INVERT, $urandom());
            else
            begin
                if (r < 14)
                    now_cursor = $urandom();
                else if (r < 16)
                    now_cursor = now_cursor - $urandom_range(0, 50);
                else
                    now_cursor = now_cursor + $urandom_range(0, step_max);
                put_word(OP_TICK, now_cursor);
            end
        end
    endtask

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        operation  = OP_TICK;
        now_ms     = '0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_PATTERN_MODE;
        cfg_data   = '0;
        calm       = 1'b0;
        hold_req   = 1'b0;
        words_sent = 0;
        settings   = 0;
        now_cursor = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values: stop mode
        put_word(OP_TICK, '0);
        put_word(OP_TICK, '1);
        put_word(OP_INVERT, '0);

        set_cfg(MODE_SOLID, 32'd1000, 8'd1, '0, '1);
        put_word(OP_TICK, 32'd5);
        put_word(OP_INVERT, '1);

        // zero period blink toggles on every tick
        set_cfg(MODE_BLINK, '0, 8'd1, '0, '1);
        put_word(OP_TICK, 32'd1);
        put_word(OP_TICK, 32'd1);
        put_word(OP_TICK, 32'd2);

        // blink with no duty stays dark
        set_cfg(MODE_BLINK, '0, 8'd1, '0, '0);
        put_word(OP_TICK, 32'd3);

        // zero period flash: dark until the gap runs out, then restart
        set_cfg(MODE_FLASH, '0, 8'd3, 32'd5, 8'd200);
        put_word(OP_TICK, 32'd10);
        put_word(OP_TICK, 32'd12);
        put_word(OP_TICK, 32'd20);

        // widest burst length
        set_cfg(MODE_FLASH, '1, '1, '1, '1);
        put_word(OP_TICK, 32'h8000_0000);
        put_word(OP_INVERT, 32'h5555_5555);
        put_word(OP_TICK, '0);

        set_cfg(MODE_PULSE, '0, 8'd1, '0, '1);
        put_word(OP_TICK, 32'd7);

        set_cfg(MODE_PULSE, '1, 8'd1, '0, '1);
        put_word(OP_TICK, 32'hFFFF_FFFE);
        put_word(OP_TICK, 32'h7FFF_FFFF);

        // undefined modes behave as stop
        for (int m = int'(MODE_PULSE) + 1; m < (1 << MODE_W); m++)
        begin
            set_cfg(MODE_W'(m), 32'd10, 8'd2, 32'd3, '1);
            put_word(OP_TICK, 32'hAAAA_AAAA);
        end

        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            calm = (p == 2);
            run_phase($urandom_range(95, 115), p == 4, p == 6);
        end
        calm = 1'b0;

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d words over %0d register settings: all modes incl. undefined,",
                 words_sent, settings + 1);
        $display("zero and full periods, count and gap extremes; %0d results compared, %0d bad",
                 checked, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("tb_led_pattern_generator_core passed");
        else
            $display("tb_led_pattern_generator_core failed");
        $finish;
    end

endmodule
